/* hdl/ccst_pkg.sv */
package ccst_pkg;

	localparam int SEC_W  = 6;
	localparam int MIN_W  = 6;
	localparam int HOUR_W = 5;
	localparam int DAY_W  = 5;
	localparam int MON_W  = 4;
	localparam int YEAR_W = 14;
	localparam int WD_W   = 3;

	localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;

	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_LOAD = 1'b1;

	// day-of-week month offsets and month lengths, January first
	localparam logic [WD_W-1:0]  MONTH_OFFSET [12] = '{3'd0, 3'd3, 3'd2, 3'd5, 3'd0, 3'd3,
		3'd5, 3'd1, 3'd4, 3'd6, 3'd2, 3'd4};
	localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

	typedef struct packed {
		logic [DAY_W-1:0]  day;
		logic [MON_W-1:0]  month;
		logic [YEAR_W-1:0] year;
	} date_t;

	typedef struct packed {
		logic              kind;
		logic [SEC_W-1:0]  sec;
		logic [MIN_W-1:0]  min;
		logic [HOUR_W-1:0] hour;
		date_t             date;
		logic              summer;
	} load_t;

	// year residues and the day-of-week base (y + y/4 - y/100 + y/400) mod 7
	typedef struct packed {
		logic [1:0]      m4;
		logic [6:0]      m100;
		logic [8:0]      m400;
		logic [WD_W-1:0] a;
	} year_info_t;

	typedef struct packed {
		logic s2;
		logic s3;
	} prep_en_t;

	localparam year_info_t INFO_RESET    = '{m4: 2'd1, m100: 7'd13, m400: 9'd13, a: 3'd2};
	localparam year_info_t INFO_YEAR_ONE = '{m4: 2'd1, m100: 7'd1, m400: 9'd1, a: 3'd1};

	function automatic logic is_leap(input year_info_t yi);
		return (yi.m400 == 9'd0) || ((yi.m100 != 7'd0) && (yi.m4 == 2'd0));
	endfunction

	function automatic logic [DAY_W-1:0] month_days(input logic leap, input logic [MON_W-1:0] m);
		logic [3:0] idx;
		idx = m - 4'd1;
		if (m == 4'd2 && leap)
			return 5'd29;
		return MONTH_LEN[idx];
	endfunction

	// fold 3-bit groups: 8 is 1 mod 7
	function automatic logic [WD_W-1:0] mod7(input logic [14:0] x);
		logic [5:0] f1;
		logic [3:0] f2;
		logic [3:0] f3;
		logic [3:0] f4;
		f1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12]);
		f2 = 4'(f1[5:3]) + 4'(f1[2:0]);
		f3 = 4'(f2[3]) + 4'(f2[2:0]);
		f4 = f3 - 4'd7;
		return (f3 >= 4'd7) ? f4[2:0] : f3[2:0];
	endfunction

	function automatic logic [WD_W-1:0] weekday_of(input year_info_t yi, input date_t d);
		logic [3:0] bt;
		logic [3:0] bm;
		logic [WD_W-1:0] base;
		logic [3:0] idx;
		logic [5:0] sum;
		// base of the previous year: a - 1 - leap
		bt   = 4'(yi.a) + 4'd6 - 4'(is_leap(yi));
		bm   = bt - 4'd7;
		idx  = d.month - 4'd1;
		base = (d.month < 4'd3) ? ((bt >= 4'd7) ? bm[2:0] : bt[2:0]) : yi.a;
		sum  = 6'(base) + 6'(MONTH_OFFSET[idx]) + 6'(d.day);
		return mod7(15'(sum));
	endfunction

	function automatic date_t next_day(input date_t d, input logic leap);
		date_t r;
		r = d;
		if (d.day >= month_days(leap, d.month)) begin
			r.day = 5'd1;
			if (d.month >= 4'd12) begin
				r.month = 4'd1;
				r.year  = (d.year >= YEAR_MAX) ? 14'd1 : d.year + 14'd1;
			end else begin
				r.month = d.month + 4'd1;
			end
		end else begin
			r.day = d.day + 5'd1;
		end
		return r;
	endfunction

endpackage

/* hdl/calendar_clock_with_summer_time_unit.sv */
// GMT clock and calendar with summer time. Each tick transfer advances the clock by one second,
// each load transfer writes time, date and summer flag (out-of-range load values saturate into
// range), and every input transfer yields exactly one result: GMT time, local hour and date
// (GMT plus one hour while summer time is on), the summer flag and the GMT weekday
// (0 = Sunday). Summer time switches on at 01:00:00 GMT on a Sunday from March 25 on, and off
// likewise from October 25 on; loads never trigger the switch. Years run 1..9999 and wrap to 1.
// The block takes one item per clock cycle; each result passes the input register, two
// year-preparation stages and the clock state register before it lands in the result
// register, and the pipeline only stalls when a finished result is not taken. After reset
// the clock reads 2013-07-26 22:59:30 GMT with summer time off.
module calendar_clock_with_summer_time_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          kind,
	input  logic [ccst_pkg::SEC_W-1:0]    load_seconds,
	input  logic [ccst_pkg::MIN_W-1:0]    load_minutes,
	input  logic [ccst_pkg::HOUR_W-1:0]   load_hours,
	input  logic [ccst_pkg::DAY_W-1:0]    load_day,
	input  logic [ccst_pkg::MON_W-1:0]    load_month,
	input  logic [ccst_pkg::YEAR_W-1:0]   load_year,
	input  logic                          load_summer,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ccst_pkg::SEC_W-1:0]    gmt_seconds,
	output logic [ccst_pkg::MIN_W-1:0]    gmt_minutes,
	output logic [ccst_pkg::HOUR_W-1:0]   gmt_hours,
	output logic [ccst_pkg::HOUR_W-1:0]   local_hours,
	output logic [ccst_pkg::DAY_W-1:0]    local_day,
	output logic [ccst_pkg::MON_W-1:0]    local_month,
	output logic [ccst_pkg::YEAR_W-1:0]   local_year,
	output logic                          summer_time,
	output logic [ccst_pkg::WD_W-1:0]     weekday
);
	import ccst_pkg::*;

	// pipeline occupancy
	logic v_s1, v_s2, v_s3, st_v_q, out_v_q;
	logic out_load, st_load, s3_load, s2_load, s1_load;
	prep_en_t prep_en;

	// payload stages
	load_t      ld_in, ld_s1, ld_s2, ld_s3;
	year_info_t info_s3;

	// clock state
	logic [SEC_W-1:0]  sec_q;
	logic [MIN_W-1:0]  min_q;
	logic [HOUR_W-1:0] hour_q;
	date_t             date_q;
	logic              summer_q;
	year_info_t        info_q;

	// next state
	logic [SEC_W-1:0]  sec_nx;
	logic [MIN_W-1:0]  min_nx;
	logic [HOUR_W-1:0] hour_nx;
	date_t             date_nx;
	logic              summer_nx;
	year_info_t        info_nx;
	logic              sec_wrap, min_wrap, day_roll, year_roll;
	date_t             tomorrow;
	year_info_t        info_inc;
	logic [3:0]        a_sum, a_sub;
	logic [WD_W-1:0]   wd_cur;
	logic              leap_cur;

	// result register
	logic [SEC_W-1:0]  o_sec_q;
	logic [MIN_W-1:0]  o_min_q;
	logic [HOUR_W-1:0] o_hour_q;
	logic [HOUR_W-1:0] o_lhour_q;
	date_t             o_ldate_q;
	logic              o_summer_q;
	logic [WD_W-1:0]   o_wd_q;
	logic [HOUR_W-1:0] lh_sum;

	// Each stage advances when the one after it is empty or advancing at the same edge.
	assign out_load = st_v_q && (!out_v_q || out_ready);
	assign st_load  = v_s3 && (!st_v_q || out_load);
	assign s3_load  = v_s2 && (!v_s3 || st_load);
	assign s2_load  = v_s1 && (!v_s2 || s3_load);
	assign in_ready = !v_s1 || s2_load;
	assign s1_load  = in_valid && in_ready;
	assign prep_en  = '{s2: s2_load, s3: s3_load};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			st_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			v_s1    <= s1_load || (v_s1 && !s2_load);
			v_s2    <= s2_load || (v_s2 && !s3_load);
			v_s3    <= s3_load || (v_s3 && !st_load);
			st_v_q  <= st_load || (st_v_q && !out_load);
			out_v_q <= out_load || (out_v_q && !out_ready);
		end
	end

	// Saturate load values into range on the way in; tick items carry them unused.
	always_comb begin
		ld_in.kind   = kind;
		ld_in.sec    = (load_seconds > 6'd59) ? 6'd59 : load_seconds;
		ld_in.min    = (load_minutes > 6'd59) ? 6'd59 : load_minutes;
		ld_in.hour   = (load_hours > 5'd23) ? 5'd23 : load_hours;
		ld_in.date.day   = (load_day == 5'd0) ? 5'd1 : load_day;
		ld_in.date.month = (load_month == 4'd0) ? 4'd1 :
			((load_month > 4'd12) ? 4'd12 : load_month);
		ld_in.date.year  = (load_year == 14'd0) ? 14'd1 :
			((load_year > YEAR_MAX) ? YEAR_MAX : load_year);
		ld_in.summer = load_summer;
	end

	always_ff @(posedge clk) begin
		if (s1_load)
			ld_s1 <= ld_in;
		if (s2_load)
			ld_s2 <= ld_s1;
		if (s3_load)
			ld_s3 <= ld_s2;
	end

	// Work out the residues and weekday base of a loaded year ahead of the state stage.
	ccst_year_prep u_year_prep (
		.clk     (clk),
		.en      (prep_en),
		.year_s1 (ld_s1.date.year),
		.info_s3 (info_s3)
	);

	assign leap_cur = is_leap(info_q);
	assign wd_cur   = weekday_of(info_q, date_q);

	// Next state: a load takes the loaded values; a tick carries seconds into minutes, hours and the date.
	always_comb begin
		sec_wrap  = (sec_q == 6'd59);
		min_wrap  = sec_wrap && (min_q == 6'd59);
		day_roll  = min_wrap && (hour_q == 5'd23);
		tomorrow  = next_day(date_q, leap_cur);
		year_roll = day_roll && (date_q.month == 4'd12) && (tomorrow.month == 4'd1);

		// step year residues forward; base grows by one plus one more in a leap year
		info_inc.m4   = info_q.m4 + 2'd1;
		info_inc.m100 = (info_q.m100 == 7'd99) ? 7'd0 : info_q.m100 + 7'd1;
		info_inc.m400 = (info_q.m400 == 9'd399) ? 9'd0 : info_q.m400 + 9'd1;
		info_inc.a    = 3'd0;
		a_sum = 4'(info_q.a) + 4'd1 + 4'(is_leap(info_inc));
		a_sub = a_sum - 4'd7;
		info_inc.a    = (a_sum >= 4'd7) ? a_sub[2:0] : a_sum[2:0];

		if (ld_s3.kind == KIND_LOAD) begin
			sec_nx    = ld_s3.sec;
			min_nx    = ld_s3.min;
			hour_nx   = ld_s3.hour;
			date_nx   = ld_s3.date;
			summer_nx = ld_s3.summer;
			info_nx   = info_s3;
		end else begin
			sec_nx    = sec_wrap ? 6'd0 : sec_q + 6'd1;
			min_nx    = sec_wrap ? (min_wrap ? 6'd0 : min_q + 6'd1) : min_q;
			hour_nx   = min_wrap ? (day_roll ? 5'd0 : hour_q + 5'd1) : hour_q;
			date_nx   = day_roll ? tomorrow : date_q;
			info_nx   = info_q;
			if (year_roll)
				info_nx = (date_q.year >= YEAR_MAX) ? INFO_YEAR_ONE : info_inc;
			// Reaching 01:00:00 means the date did not change, so the current weekday holds.
			summer_nx = summer_q;
			if (min_wrap && hour_q == 5'd0 && wd_cur == 3'd0 && date_q.day >= 5'd25) begin
				if (date_q.month == 4'd3)
					summer_nx = 1'b1;
				else if (date_q.month == 4'd10)
					summer_nx = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q    <= 6'd30;
			min_q    <= 6'd59;
			hour_q   <= 5'd22;
			date_q   <= '{day: 5'd26, month: 4'd7, year: 14'd2013};
			summer_q <= 1'b0;
			info_q   <= INFO_RESET;
		end else if (st_load) begin
			sec_q    <= sec_nx;
			min_q    <= min_nx;
			hour_q   <= hour_nx;
			date_q   <= date_nx;
			summer_q <= summer_nx;
			info_q   <= info_nx;
		end
	end

	// Result: local view of the state that the item just left.
	assign lh_sum = hour_q + 5'(summer_q);

	always_ff @(posedge clk) begin
		if (out_load) begin
			o_sec_q    <= sec_q;
			o_min_q    <= min_q;
			o_hour_q   <= hour_q;
			o_lhour_q  <= (lh_sum >= 5'd24) ? 5'd0 : lh_sum;
			o_ldate_q  <= (lh_sum >= 5'd24) ? tomorrow : date_q;
			o_summer_q <= summer_q;
			o_wd_q     <= wd_cur;
		end
	end

	assign out_valid   = out_v_q;
	assign gmt_seconds = o_sec_q;
	assign gmt_minutes = o_min_q;
	assign gmt_hours   = o_hour_q;
	assign local_hours = o_lhour_q;
	assign local_day   = o_ldate_q.day;
	assign local_month = o_ldate_q.month;
	assign local_year  = o_ldate_q.year;
	assign summer_time = o_summer_q;
	assign weekday     = o_wd_q;

endmodule

/* hdl/ccst_year_prep.sv */
module ccst_year_prep (
	input  logic                           clk,
	input  ccst_pkg::prep_en_t             en,
	input  logic [ccst_pkg::YEAR_W-1:0]    year_s1,
	output ccst_pkg::year_info_t           info_s3
);
	import ccst_pkg::*;

	logic [26:0]       prod;
	logic [YEAR_W-1:0] year_s2;
	logic [6:0]        q100_s2;
	logic [4:0]        q400;
	logic [YEAR_W-1:0] r100;
	logic [YEAR_W-1:0] r400;
	logic [14:0]       base_sum;
	year_info_t        info_nx;

	// y / 100 as (y * 5243) >> 19, exact below 10000
	assign prod = 27'(year_s1) * 27'd5243;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			year_s2 <= year_s1;
			q100_s2 <= prod[25:19];
		end
	end

	always_comb begin
		q400     = q100_s2[6:2];
		r100     = year_s2 - 14'(q100_s2) * 14'd100;
		r400     = year_s2 - 14'(q400) * 14'd400;
		base_sum = 15'(year_s2) + 15'(year_s2[13:2]) - 15'(q100_s2) + 15'(q400);
		info_nx.m4   = year_s2[1:0];
		info_nx.m100 = r100[6:0];
		info_nx.m400 = r400[8:0];
		info_nx.a    = mod7(base_sum);
	end

	always_ff @(posedge clk) begin
		if (en.s3)
			info_s3 <= info_nx;
	end

endmodule

/* test/calendar_clock_checker.sv */
`timescale 1ns / 1ps
module calendar_clock_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic                        kind,
	input  logic [ccst_pkg::SEC_W-1:0]  load_seconds,
	input  logic [ccst_pkg::MIN_W-1:0]  load_minutes,
	input  logic [ccst_pkg::HOUR_W-1:0] load_hours,
	input  logic [ccst_pkg::DAY_W-1:0]  load_day,
	input  logic [ccst_pkg::MON_W-1:0]  load_month,
	input  logic [ccst_pkg::YEAR_W-1:0] load_year,
	input  logic                        load_summer,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [ccst_pkg::SEC_W-1:0]  gmt_seconds,
	input  logic [ccst_pkg::MIN_W-1:0]  gmt_minutes,
	input  logic [ccst_pkg::HOUR_W-1:0] gmt_hours,
	input  logic [ccst_pkg::HOUR_W-1:0] local_hours,
	input  logic [ccst_pkg::DAY_W-1:0]  local_day,
	input  logic [ccst_pkg::MON_W-1:0]  local_month,
	input  logic [ccst_pkg::YEAR_W-1:0] local_year,
	input  logic                        summer_time,
	input  logic [ccst_pkg::WD_W-1:0]   weekday,
	output int                          failures,
	output int                          pending
);
	import ccst_pkg::*;

	typedef struct packed {
		logic [SEC_W-1:0]  sec;
		logic [MIN_W-1:0]  min;
		logic [HOUR_W-1:0] hr;
		logic [HOUR_W-1:0] lhr;
		logic [DAY_W-1:0]  lday;
		logic [MON_W-1:0]  lmon;
		logic [YEAR_W-1:0] lyear;
		logic              summer;
		logic [WD_W-1:0]   wday;
	} reading_t;

	reading_t expected_readings[$];
	int err_count = 0;

	// clock state after reset: 2013-07-26 22:59:30 GMT, winter
	int sec_now = 30;
	int min_now = 59;
	int hour_now = 22;
	int day_now = 26;
	int mon_now = 7;
	int year_now = 2013;
	int summer_now = 0;

	function automatic bit leap(input int y);
		return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
	endfunction

	function automatic int month_length(input int y, input int m);
		case (m)
			2: return leap(y) ? 29 : 28;
			4, 6, 9, 11: return 30;
			default: return 31;
		endcase
	endfunction

	function automatic int month_shift(input int m);
		case (m)
			1, 5: return 0;
			2, 6: return 3;
			3, 11: return 2;
			4: return 5;
			7: return 5;
			8: return 1;
			9: return 4;
			10: return 6;
			default: return 4;
		endcase
	endfunction

	// Sakamoto: January and February count against the previous year
	function automatic int weekday_of_date(input int y, input int m, input int d);
		int yy;
		yy = (m < 3) ? y - 1 : y;
		return (yy + yy / 4 - yy / 100 + yy / 400 + month_shift(m) + d) % 7;
	endfunction

	function automatic int clamp(input int v, input int lo, input int hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// a day past the month's end (loaded Feb 31) also carries to the 1st
	task automatic step_day(inout int d, inout int m, inout int y);
		d++;
		if (d > month_length(y, m)) begin
			d = 1;
			m++;
			if (m > 12) begin
				m = 1;
				y = (y >= 9999) ? 1 : y + 1;
			end
		end
	endtask

	task automatic advance_clock(input logic k, input int s, input int mi, input int h,
			input int d, input int mo, input int y, input int su, output reading_t r);
		int lh;
		int ld;
		int lm;
		int ly;
		int wd;
		if (k == KIND_LOAD) begin
			sec_now = clamp(s, 0, 59);
			min_now = clamp(mi, 0, 59);
			hour_now = clamp(h, 0, 23);
			day_now = clamp(d, 1, 31);
			mon_now = clamp(mo, 1, 12);
			year_now = clamp(y, 1, 9999);
			summer_now = su;
		end else begin
			sec_now++;
			if (sec_now >= 60) begin
				sec_now = 0;
				min_now++;
				if (min_now >= 60) begin
					min_now = 0;
					hour_now++;
					if (hour_now >= 24) begin
						hour_now = 0;
						step_day(day_now, mon_now, year_now);
					end
				end
			end
			// switch only on a tick landing on Sunday 01:00:00 GMT
			if (sec_now == 0 && min_now == 0 && hour_now == 1 &&
					weekday_of_date(year_now, mon_now, day_now) == 0) begin
				if (mon_now == 3 && day_now >= 25)
					summer_now = 1;
				else if (mon_now == 10 && day_now >= 25)
					summer_now = 0;
			end
		end
		lh = hour_now + summer_now;
		ld = day_now;
		lm = mon_now;
		ly = year_now;
		if (lh >= 24) begin
			lh -= 24;
			step_day(ld, lm, ly);
		end
		wd = weekday_of_date(year_now, mon_now, day_now);
		r.sec = sec_now[SEC_W-1:0];
		r.min = min_now[MIN_W-1:0];
		r.hr = hour_now[HOUR_W-1:0];
		r.lhr = lh[HOUR_W-1:0];
		r.lday = ld[DAY_W-1:0];
		r.lmon = lm[MON_W-1:0];
		r.lyear = ly[YEAR_W-1:0];
		r.summer = summer_now[0];
		r.wday = wd[WD_W-1:0];
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			err_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		reading_t want;
		reading_t r;
		if (!arst_n) begin
			sec_now = 30;
			min_now = 59;
			hour_now = 22;
			day_now = 26;
			mon_now = 7;
			year_now = 2013;
			summer_now = 0;
			expected_readings.delete();
		end else begin
			// retire the output first: an input taken on this edge cannot be its source
			if (out_valid && out_ready) begin
				if (expected_readings.size() == 0) begin
					$display("%0t: unexpected result, got %0d:%0d:%0d", $time,
						gmt_hours, gmt_minutes, gmt_seconds);
					err_count++;
				end else begin
					want = expected_readings.pop_front();
					check_field("gmt_seconds", want.sec, gmt_seconds);
					check_field("gmt_minutes", want.min, gmt_minutes);
					check_field("gmt_hours", want.hr, gmt_hours);
					check_field("local_hours", want.lhr, local_hours);
					check_field("local_day", want.lday, local_day);
					check_field("local_month", want.lmon, local_month);
					check_field("local_year", want.lyear, local_year);
					check_field("summer_time", want.summer, summer_time);
					check_field("weekday", want.wday, weekday);
				end
			end
			if (in_valid && in_ready) begin
				advance_clock(kind, load_seconds, load_minutes, load_hours, load_day,
					load_month, load_year, load_summer, r);
				expected_readings.push_back(r);
			end
		end
		failures <= err_count;
		pending <= expected_readings.size();
	end

endmodule

/* test/calendar_clock_with_summer_time_unit_tb.sv */
`timescale 1ns / 1ps
module calendar_clock_with_summer_time_unit_tb;
	import ccst_pkg::*;

	localparam int RANDOM_ITEMS = 600;
	localparam int CYCLE_LIMIT  = 300000;
	// idle time after the final drain, to give the tail a comfortable margin
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES  = 64;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic              kind;
	logic [SEC_W-1:0]  load_seconds;
	logic [MIN_W-1:0]  load_minutes;
	logic [HOUR_W-1:0] load_hours;
	logic [DAY_W-1:0]  load_day;
	logic [MON_W-1:0]  load_month;
	logic [YEAR_W-1:0] load_year;
	logic              load_summer;
	logic              out_valid;
	logic              out_ready;
	logic [SEC_W-1:0]  gmt_seconds;
	logic [MIN_W-1:0]  gmt_minutes;
	logic [HOUR_W-1:0] gmt_hours;
	logic [HOUR_W-1:0] local_hours;
	logic [DAY_W-1:0]  local_day;
	logic [MON_W-1:0]  local_month;
	logic [YEAR_W-1:0] local_year;
	logic              summer_time;
	logic [WD_W-1:0]   weekday;

	int failures;
	int pending;
	int cycles = 0;
	int sent = 0;
	// 0: back-to-back transfers, 1: random gaps between transfers
	int gap_mode = 0;
	// request and acknowledge of the one long output hold-off
	bit stall_out = 1'b0;
	bit stall_done = 1'b0;

	always #5 clk = ~clk;

	calendar_clock_with_summer_time_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.load_seconds (load_seconds),
		.load_minutes (load_minutes),
		.load_hours   (load_hours),
		.load_day     (load_day),
		.load_month   (load_month),
		.load_year    (load_year),
		.load_summer  (load_summer),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.gmt_seconds  (gmt_seconds),
		.gmt_minutes  (gmt_minutes),
		.gmt_hours    (gmt_hours),
		.local_hours  (local_hours),
		.local_day    (local_day),
		.local_month  (local_month),
		.local_year   (local_year),
		.summer_time  (summer_time),
		.weekday      (weekday)
	);

	calendar_clock_checker calendar_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.load_seconds (load_seconds),
		.load_minutes (load_minutes),
		.load_hours   (load_hours),
		.load_day     (load_day),
		.load_month   (load_month),
		.load_year    (load_year),
		.load_summer  (load_summer),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.gmt_seconds  (gmt_seconds),
		.gmt_minutes  (gmt_minutes),
		.gmt_hours    (gmt_hours),
		.local_hours  (local_hours),
		.local_day    (local_day),
		.local_month  (local_month),
		.local_year   (local_year),
		.summer_time  (summer_time),
		.weekday      (weekday),
		.failures     (failures),
		.pending      (pending)
	);

	// Bound the run: a hung handshake ends here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[calendar_clock_with_summer_time_unit] ERROR");
			$finish;
		end
	end

	// Pick the idle time after a transfer: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		if (gap_mode == 0)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 25);
	endfunction

	// Offer one item and hold it until the transfer. Leave valid high when no gap
	// follows, so the next item goes out without valid dropping in between.
	task automatic send(input logic k, input int s, input int mi, input int h, input int d,
			input int mo, input int y, input int su);
		int gap;
		in_valid <= 1'b1;
		kind <= k;
		load_seconds <= s[SEC_W-1:0];
		load_minutes <= mi[MIN_W-1:0];
		load_hours <= h[HOUR_W-1:0];
		load_day <= d[DAY_W-1:0];
		load_month <= mo[MON_W-1:0];
		load_year <= y[YEAR_W-1:0];
		load_summer <= su[0];
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent++;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic load_time(input int s, input int mi, input int h, input int d,
			input int mo, input int y, input int su);
		send(KIND_LOAD, s, mi, h, d, mo, y, su);
	endtask

	// Ticks carry random junk in the load fields: the block must ignore it.
	task automatic tick_run(input int n);
		repeat (n)
			send(KIND_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom);
	endtask

	// Drop valid and wait until every outstanding result has come back. Skip one
	// edge first so the count includes a transfer made on the current edge.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Years weighted toward the wrap point, century rules and tiny values.
	function automatic int pick_year();
		case ($urandom_range(0, 7))
			0: return 9999;
			1: begin
				case ($urandom_range(0, 3))
					0: return 1900;
					1: return 2000;
					2: return 2100;
					default: return 2400;
				endcase
			end
			2: return $urandom_range(1, 20);
			default: return $urandom_range(1, 9999);
		endcase
	endfunction

	// Receiver: runs of ready with short idles, sometimes long ones, plus the one
	// long hold-off that lets the pipeline fill and push back on the sender.
	initial begin : receiver
		int run_left;
		int idle_left;
		run_left = 0;
		idle_left = 0;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (stall_out && !stall_done) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				stall_done = 1'b1;
				out_ready <= 1'b1;
			end else if (run_left > 0) begin
				out_ready <= 1'b1;
				run_left--;
			end else if (idle_left > 0) begin
				out_ready <= 1'b0;
				idle_left--;
			end else begin
				run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) :
					$urandom_range(1, 8);
				idle_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) :
					$urandom_range(0, 2);
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int rand_start;
		int seq_count;
		int pick;
		int anchor;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		kind <= KIND_TICK;
		load_seconds <= '0;
		load_minutes <= '0;
		load_hours <= '0;
		load_day <= '0;
		load_month <= '0;
		load_year <= '0;
		load_summer <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: advance from the reset time first.
		gap_mode = 0;
		tick_run(2);
		// Sunday March 24: too early in the month, stay in winter time.
		load_time(59, 59, 0, 24, 3, 2024, 0);
		tick_run(1);
		// Last Sunday of March: switch summer time on at 01:00:00 GMT.
		load_time(59, 59, 0, 31, 3, 2024, 0);
		tick_run(2);
		// Load right at the switch instant: the flag must come from the load.
		load_time(0, 0, 1, 31, 3, 2024, 0);
		// Last Sunday of October: switch summer time off.
		load_time(59, 59, 0, 27, 10, 2024, 1);
		tick_run(1);
		// Wrap from 9999-12-31 to year 1, on the GMT count and on the local date.
		load_time(59, 59, 23, 31, 12, 9999, 0);
		tick_run(1);
		load_time(0, 30, 23, 31, 12, 9999, 1);
		// Day past the month's end carries to March 1, GMT and local.
		load_time(59, 59, 23, 31, 2, 2023, 0);
		tick_run(1);
		load_time(0, 10, 23, 31, 2, 2023, 1);
		// Leap rules: divisible by 4, century years, and the 400-year exception.
		load_time(59, 59, 23, 28, 2, 2024, 0);
		tick_run(1);
		load_time(59, 59, 23, 28, 2, 1900, 0);
		tick_run(1);
		load_time(59, 59, 23, 28, 2, 2000, 0);
		tick_run(1);
		// Saturate out-of-range load values, all ones then all zeros.
		load_time(63, 63, 31, 31, 15, 16383, 1);
		tick_run(1);
		load_time(0, 0, 0, 0, 0, 0, 0);
		tick_run(1);
		drain();

		// Random: start with the long output hold-off while the sender keeps pushing.
		rand_start = sent;
		seq_count = 0;
		stall_out = 1'b1;
		tick_run(30);
		drain();
		while (sent - rand_start < RANDOM_ITEMS) begin
			gap_mode = ($urandom_range(0, 3) == 0) ? 0 : 1;
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				// Near a minute, hour, day or year boundary, then tick across it.
				load_time($urandom_range(45, 59),
					$urandom_range(0, 1) ? 59 : $urandom_range(0, 59),
					$urandom_range(0, 1) ? 23 : $urandom_range(0, 23),
					$urandom_range(0, 1) ? $urandom_range(27, 31) : $urandom_range(1, 31),
					$urandom_range(1, 12), pick_year(), $urandom_range(0, 1));
				tick_run($urandom_range(1, 20));
			end else if (pick < 55) begin
				// Just before 01:00 GMT late in March or October. Half of them use
				// known last Sundays so the switch really fires.
				if ($urandom_range(0, 1)) begin
					anchor = $urandom_range(0, 5);
					case (anchor)
						0: load_time($urandom_range(55, 59), 59, 0, 26, 3, 2023,
							$urandom_range(0, 1));
						1: load_time($urandom_range(55, 59), 59, 0, 29, 10, 2023,
							$urandom_range(0, 1));
						2: load_time($urandom_range(55, 59), 59, 0, 31, 3, 2024,
							$urandom_range(0, 1));
						3: load_time($urandom_range(55, 59), 59, 0, 27, 10, 2024,
							$urandom_range(0, 1));
						4: load_time($urandom_range(55, 59), 59, 0, 30, 3, 2025,
							$urandom_range(0, 1));
						default: load_time($urandom_range(55, 59), 59, 0, 26, 10, 2025,
							$urandom_range(0, 1));
					endcase
				end else begin
					load_time($urandom_range(55, 59), 59, 0,
						($urandom_range(0, 4) == 0) ? $urandom_range(18, 24) :
						$urandom_range(25, 31),
						$urandom_range(0, 1) ? 3 : 10, pick_year(), $urandom_range(0, 1));
				end
				tick_run($urandom_range(2, 12));
			end else if (pick < 70) begin
				// Noise: every load bit random, out-of-range values included.
				send(KIND_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom);
				tick_run($urandom_range(0, 3));
			end else if (pick < 85) begin
				tick_run($urandom_range(1, 20));
			end else begin
				load_time($urandom_range(0, 59), $urandom_range(0, 59),
					$urandom_range(0, 23), $urandom_range(1, 31), $urandom_range(1, 12),
					pick_year(), $urandom_range(0, 1));
				tick_run($urandom_range(1, 5));
			end
			seq_count++;
			// Pause the sender once mid-run until the pipeline is empty.
			if (seq_count == 40)
				drain();
		end

		// Let every result come home, then a few more cycles for strays.
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("[calendar_clock_with_summer_time_unit] OK");
		else
			$display("[calendar_clock_with_summer_time_unit] ERROR");
		$finish;
	end

endmodule
